### hdl/stok_pkg.sv
// stok_pkg: token record, token kind codes and character constants for the tokenizer
// used by stok_front, stok_queue, stok_back and source_tokenizer
// depends on nothing
`default_nettype none

package stok_pkg;

	// defaults for the top-level parameters
	localparam int POS_WIDTH_DEFAULT   = 16;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// token kind codes
	localparam logic [3:0] KIND_LPAREN       = 4'd0;
	localparam logic [3:0] KIND_RPAREN       = 4'd1;
	localparam logic [3:0] KIND_ARROW        = 4'd2;
	localparam logic [3:0] KIND_LCURLY       = 4'd3;
	localparam logic [3:0] KIND_RCURLY       = 4'd4;
	localparam logic [3:0] KIND_SEMI         = 4'd5;
	localparam logic [3:0] KIND_IDENT        = 4'd6;
	localparam logic [3:0] KIND_INT          = 4'd7;
	localparam logic [3:0] KIND_END          = 4'd8;
	localparam logic [3:0] KIND_BAD_ARROW    = 4'd9;
	localparam logic [3:0] KIND_UNRECOGNIZED = 4'd10;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

	// one output token
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [30:0] value;
		logic [7:0]  bad;
	} token_t;

	// all tokens caused by one input byte; tok0 always present
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} token_pair_t;

	// saturating increment against a limit
	function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] lim);
		return (v < lim) ? v + 16'd1 : lim;
	endfunction

endpackage

`default_nettype wire

### hdl/stok_front.sv
// stok_front: scanner state and byte classifier; turns each byte into zero, one or two tokens
// depends on stok_pkg; feeds stok_queue
`default_nettype none

module stok_front #(
	parameter int POSITION_WIDTH = stok_pkg::POS_WIDTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	input  wire logic [7:0]         byte_code,
	input  wire logic               queue_full,
	output logic                    byte_ready,
	output logic                    push,
	output stok_pkg::token_pair_t   push_data
);
	import stok_pkg::*;

	localparam logic [15:0] POS_LIMIT = (POSITION_WIDTH >= 16) ? 16'hFFFF :
		16'((33'd1 << POSITION_WIDTH) - 33'd1);

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_DASH  = 3'd1,
		M_IDENT = 3'd2,
		M_INT   = 3'd3,
		M_ERROR = 3'd4
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] pstart_q, pstart_d;
	logic [15:0] plen_q, plen_d;
	logic [30:0] pval_q, pval_d;

	logic        accept;
	logic        is_space, is_letter, is_digit, is_nul;
	logic [15:0] pos_inc;

	// idle-mode handling of the current byte
	logic        idle_has;
	token_t      idle_tok;
	mode_t       idle_mode;
	logic [15:0] idle_pos, idle_pstart, idle_plen;
	logic [30:0] idle_pval;

	// result of this byte
	logic        has0;
	logic        two;
	token_t      tok0, tok1;

	logic [34:0] acc_wide;
	logic [30:0] acc_sat;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;

	// byte classes
	assign is_nul    = (byte_code == CH_NUL);
	assign is_space  = (byte_code == 8'h20) || (byte_code >= 8'h09 && byte_code <= 8'h0D);
	assign is_letter = (byte_code >= 8'h61 && byte_code <= 8'h7A) ||
		(byte_code >= 8'h41 && byte_code <= 8'h5A) || (byte_code == CH_UNDER);
	assign is_digit  = (byte_code >= 8'h30 && byte_code <= 8'h39);
	assign pos_inc   = sat_inc(pos_q, POS_LIMIT);

	// decimal accumulate: v*10 + digit as shifts and adds, then clamp
	assign acc_wide = ({4'b0, pval_q} << 3) + ({4'b0, pval_q} << 1) + {31'b0, byte_code[3:0]};
	assign acc_sat  = (acc_wide > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc_wide[30:0];

	// idle-mode handler
	always_comb begin
		idle_has    = 1'b0;
		idle_tok    = '0;
		idle_tok.start  = pos_q;
		idle_tok.length = 16'd1;
		idle_mode   = M_IDLE;
		idle_pos    = pos_inc;
		idle_pstart = pstart_q;
		idle_plen   = plen_q;
		idle_pval   = pval_q;
		if (is_nul) begin
			idle_has        = 1'b1;
			idle_tok.kind   = KIND_END;
			idle_tok.length = 16'd0;
			idle_pos        = 16'd0;
		end else if (is_space) begin
			idle_has = 1'b0;
		end else if (byte_code == CH_LPAREN) begin
			idle_has      = 1'b1;
			idle_tok.kind = KIND_LPAREN;
		end else if (byte_code == CH_RPAREN) begin
			idle_has      = 1'b1;
			idle_tok.kind = KIND_RPAREN;
		end else if (byte_code == CH_LCURLY) begin
			idle_has      = 1'b1;
			idle_tok.kind = KIND_LCURLY;
		end else if (byte_code == CH_RCURLY) begin
			idle_has      = 1'b1;
			idle_tok.kind = KIND_RCURLY;
		end else if (byte_code == CH_SEMI) begin
			idle_has      = 1'b1;
			idle_tok.kind = KIND_SEMI;
		end else if (byte_code == CH_DASH) begin
			idle_mode   = M_DASH;
			idle_pstart = pos_q;
		end else if (is_letter) begin
			idle_mode   = M_IDENT;
			idle_pstart = pos_q;
			idle_plen   = 16'd1;
		end else if (is_digit) begin
			idle_mode   = M_INT;
			idle_pstart = pos_q;
			idle_plen   = 16'd1;
			idle_pval   = {27'b0, byte_code[3:0]};
		end else begin
			idle_has      = 1'b1;
			idle_tok.kind = KIND_UNRECOGNIZED;
			idle_tok.bad  = byte_code;
			idle_mode     = M_ERROR;
		end
	end

	// per-mode next state and tokens
	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		pval_d   = pval_q;
		has0     = 1'b0;
		two      = 1'b0;
		tok0     = '0;
		tok1     = '0;
		case (mode_q)
			M_DASH: begin
				has0       = 1'b1;
				tok0.start = pstart_q;
				if (byte_code == CH_GT) begin
					tok0.kind   = KIND_ARROW;
					tok0.length = 16'd2;
					mode_d      = M_IDLE;
					pos_d       = pos_inc;
				end else begin
					tok0.kind   = KIND_BAD_ARROW;
					tok0.length = is_nul ? 16'd1 : 16'd2;
					tok0.bad    = byte_code;
					if (is_nul) begin
						two         = 1'b1;
						tok1.kind   = KIND_END;
						tok1.start  = pos_q;
						tok1.length = 16'd0;
						mode_d      = M_IDLE;
						pos_d       = 16'd0;
					end else begin
						mode_d = M_ERROR;
						pos_d  = pos_inc;
					end
				end
			end
			M_IDENT, M_INT: begin
				if (is_digit || (is_letter && mode_q == M_IDENT)) begin
					plen_d = sat_inc(plen_q, POS_LIMIT);
					pos_d  = pos_inc;
					if (mode_q == M_INT) begin
						pval_d = acc_sat;
					end
				end else begin
					has0        = 1'b1;
					tok0.kind   = (mode_q == M_INT) ? KIND_INT : KIND_IDENT;
					tok0.start  = pstart_q;
					tok0.length = plen_q;
					tok0.value  = (mode_q == M_INT) ? pval_q : 31'd0;
					two         = idle_has;
					tok1        = idle_tok;
					mode_d      = idle_mode;
					pos_d       = idle_pos;
					pstart_d    = idle_pstart;
					plen_d      = idle_plen;
					pval_d      = idle_pval;
				end
			end
			M_ERROR: begin
				if (is_nul) begin
					has0        = 1'b1;
					tok0.kind   = KIND_END;
					tok0.start  = pos_q;
					tok0.length = 16'd0;
					mode_d      = M_IDLE;
					pos_d       = 16'd0;
				end else begin
					pos_d = pos_inc;
				end
			end
			default: begin
				has0     = idle_has;
				tok0     = idle_tok;
				mode_d   = idle_mode;
				pos_d    = idle_pos;
				pstart_d = idle_pstart;
				plen_d   = idle_plen;
				pval_d   = idle_pval;
			end
		endcase
	end

	assign push           = accept && has0;
	assign push_data.two  = two;
	assign push_data.tok0 = tok0;
	assign push_data.tok1 = tok1;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= 16'd0;
			pstart_q <= 16'd0;
			plen_q   <= 16'd0;
			pval_q   <= 31'd0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			pval_q   <= pval_d;
		end
	end

	// a pending identifier or integer always has at least one byte
	a_plen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDENT || mode_q == M_INT) |-> (plen_q != 16'd0))
		else $error("pending token with zero length");

	// position never passes the saturation limit
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= POS_LIMIT) && (plen_q <= POS_LIMIT))
		else $error("position or length beyond limit");

	// a second token only ever follows a first one
	a_two_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && two) |-> push)
		else $error("second token without first");

endmodule

`default_nettype wire

### hdl/stok_queue.sv
// stok_queue: short register queue of token pairs between front and back
// depends on stok_pkg
`default_nettype none

module stok_queue #(
	parameter int DEPTH = stok_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire stok_pkg::token_pair_t push_data,
	input  wire logic                  pop,
	output logic                       full,
	output logic                       empty,
	output stok_pkg::token_pair_t      head
);
	import stok_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	token_pair_t   slot_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

### hdl/stok_back.sv
// stok_back: unpacks token pairs into single output transfers and holds the output register
// depends on stok_pkg; reads from stok_queue
`default_nettype none

module stok_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  empty,
	input  wire stok_pkg::token_pair_t head,
	output logic                       pop,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output stok_pkg::token_t           out_tok,
	output logic                       out_last
);
	import stok_pkg::*;

	logic   out_valid_q;
	token_t out_tok_q;
	logic   out_last_q;
	logic   second_q;
	logic   load;
	logic   first_of_two;

	// output register free or draining this cycle
	assign load         = (!out_valid_q || out_ready) && !empty;
	assign first_of_two = head.two && !second_q;
	assign pop          = load && !first_of_two;

	assign out_valid = out_valid_q;
	assign out_tok   = out_tok_q;
	assign out_last  = out_last_q;

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q  <= second_q ? head.tok1 : head.tok0;
			out_last_q <= !first_of_two;
		end
	end

	// output valid and pair phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= first_of_two;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// while the second token waits, the first one is still held or just replaced
	a_second_held: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (out_valid_q && !out_last_q && !empty))
		else $error("pair phase without its first token");

	// a pair is popped only on its final token
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_last_q)
		else $error("pair popped before its last token");

	// a token waiting on the output keeps valid and payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_tok_q)))
		else $error("output token dropped or changed while waiting");

endmodule

`default_nettype wire

### hdl/source_tokenizer.sv
// source_tokenizer: top level of the streaming source tokenizer
// depends on stok_pkg, stok_front, stok_queue, stok_back
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | in_valid, in_ready, char_code            | in
//  output   | out_valid, out_ready, token_kind,        | out
//           | start_offset, token_length, int_value,   |
//           | bad_byte, run_last                       |
//
// one source byte is taken per cycle while the queue is not full; the output side
// moves one token per cycle while out_ready is high, so a byte that ends an
// identifier or integer and also makes a token of its own costs two output transfers
// a queue of QUEUE_DEPTH byte results lets either side stall without stopping the other
// asynchronous reset returns the scanner to idle at offset zero; no clearing pass
`default_nettype none

module source_tokenizer #(
	parameter int POSITION_WIDTH = stok_pkg::POS_WIDTH_DEFAULT,
	parameter int QUEUE_DEPTH    = stok_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       token_kind,
	output logic [15:0]      start_offset,
	output logic [15:0]      token_length,
	output logic [30:0]      int_value,
	output logic [7:0]       bad_byte,
	output logic             run_last
);
	import stok_pkg::*;

	logic        push, pop, full, empty;
	token_pair_t push_data, head;
	token_t      out_tok;

	// front: classify bytes and run the scanner
	stok_front #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (in_valid),
		.byte_code  (char_code),
		.queue_full (full),
		.byte_ready (in_ready),
		.push       (push),
		.push_data  (push_data)
	);

	// queue of token pairs
	stok_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	// back: one token per output transfer
	stok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_tok   (out_tok),
		.out_last  (run_last)
	);

	assign token_kind   = out_tok.kind;
	assign start_offset = out_tok.start;
	assign token_length = out_tok.length;
	assign int_value    = out_tok.value;
	assign bad_byte     = out_tok.bad;

endmodule

`default_nettype wire
